// ===== rtl/ocpu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocpu_pkg
// Shared types, constants and tables for the orbit camera pose unit.
// ----------------------------------------------------------------------------
package ocpu_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int ANG_FRAC     = 22;
   localparam int CORDIC_STEPS = 24;
   localparam int STEP_W       = 5;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic signed [47:0] FX_ONE  = 48'sd1 <<< FRAC_BITS;
   localparam logic signed [47:0] FX_89   = 48'sd89 <<< FRAC_BITS;
   localparam logic signed [47:0] FX_360  = 48'sd360 <<< FRAC_BITS;
   localparam logic signed [47:0] FX_10   = 48'sd10 <<< FRAC_BITS;
   localparam logic signed [47:0] FX_30   = 48'sd30 <<< FRAC_BITS;
   localparam logic signed [47:0] FX_100  = 48'sd100 <<< FRAC_BITS;

   localparam logic signed [35:0] ANG_FULL  = 36'sd360 <<< ANG_FRAC;
   localparam logic signed [35:0] ANG_HALF  = 36'sd180 <<< ANG_FRAC;
   localparam logic signed [35:0] ANG_QUART = 36'sd90 <<< ANG_FRAC;

   localparam logic [1:0] OP_ORBIT = 2'd0;
   localparam logic [1:0] OP_ZOOM  = 2'd1;
   localparam logic [1:0] OP_PAN   = 2'd2;
   localparam logic [1:0] OP_SET   = 2'd3;

   localparam logic [2:0] REG_MIN_DIST = 3'd0;
   localparam logic [2:0] REG_MAX_DIST = 3'd4;

   // datapath commands
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,      // capture item and apply orbit/zoom/set
      CMD_CS_HEAD,   // start cordic on heading
      CMD_CS_TILT,   // start cordic on tilt
      CMD_CS_STEP,   // one cordic iteration
      CMD_CS_HEAD_DONE,
      CMD_CS_TILT_DONE,
      CMD_MUL,       // one multiply slot, selected by mul_sel
      CMD_PAN_DONE,
      CMD_OUT        // build result
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
      logic [3:0]   mul_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       cordic_last;
   } dp_status_type;

   function automatic logic signed [35:0] atan_lut(input logic [STEP_W-1:0] i);
      logic signed [35:0] r;
      r = '0;
      case (i)
         5'd0:  r = 36'sd188743680;
         5'd1:  r = 36'sd111421900;
         5'd2:  r = 36'sd58872272;
         5'd3:  r = 36'sd29884485;
         5'd4:  r = 36'sd15000234;
         5'd5:  r = 36'sd7507429;
         5'd6:  r = 36'sd3754631;
         5'd7:  r = 36'sd1877430;
         5'd8:  r = 36'sd938729;
         5'd9:  r = 36'sd469366;
         5'd10: r = 36'sd234683;
         5'd11: r = 36'sd117342;
         5'd12: r = 36'sd58671;
         5'd13: r = 36'sd29335;
         5'd14: r = 36'sd14668;
         5'd15: r = 36'sd7334;
         5'd16: r = 36'sd3667;
         5'd17: r = 36'sd1833;
         5'd18: r = 36'sd917;
         5'd19: r = 36'sd458;
         5'd20: r = 36'sd229;
         5'd21: r = 36'sd115;
         5'd22: r = 36'sd57;
         5'd23: r = 36'sd29;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      if (v > 48'sh7FFF_FFFF)
         return 32'sh7FFF_FFFF;
      else if (v < -48'sh8000_0000)
         return -32'sh8000_0000;
      else
         return v[31:0];
   endfunction

endpackage

// ===== rtl/ocpu_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocpu_req_if / ocpu_rsp_if
// Valid/ready channels for items and results.
// ----------------------------------------------------------------------------
interface ocpu_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic signed [25:0] yaw_step;
   logic signed [31:0] pitch_step;
   logic signed [31:0] zoom_delta;
   logic signed [31:0] pan_right;
   logic signed [31:0] pan_up;
   logic signed [31:0] new_target_x;
   logic signed [31:0] new_target_y;
   logic signed [31:0] new_target_z;
   modport source (output valid, op, yaw_step, pitch_step, zoom_delta,
                   pan_right, pan_up, new_target_x, new_target_y, new_target_z,
                   input ready);
   modport sink (input valid, op, yaw_step, pitch_step, zoom_delta,
                 pan_right, pan_up, new_target_x, new_target_y, new_target_z,
                 output ready);
endinterface

interface ocpu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] cam_x;
   logic signed [31:0] cam_y;
   logic signed [31:0] cam_z;
   logic signed [31:0] look_x;
   logic signed [31:0] look_y;
   logic signed [31:0] look_z;
   logic [30:0]        range_now;
   modport source (output valid, cam_x, cam_y, cam_z, look_x, look_y, look_z,
                   range_now, input ready);
   modport sink (input valid, cam_x, cam_y, cam_z, look_x, look_y, look_z,
                 range_now, output ready);
endinterface

// ===== rtl/orbit_camera_pose_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orbit_camera_pose_update
// Orbit camera: applies orbit/zoom/pan/set-target and returns the pose.
// ----------------------------------------------------------------------------
// Items arrive on req (valid/ready); each op updates target, distance,
// azimuth or elevation, and one result (camera position, target, distance)
// leaves on rsp. min/max distance sit at csr byte addresses 0 and 4.
// Orbit, zoom and set target run two 24-step CORDIC passes (heading, then
// tilt) and four multiply slots; pan also runs six multiply slots and then
// both sine/cosine passes again. One shared CORDIC and one 32x32 multiplier
// do this work, and one item at a time is in flight.
// Reset restores target 0, distance 10, azimuth 0, elevation 30 and the
// distance limits 1 and 100. A stalled rsp holds its result and req_ready
// stays low until the result is transferred.
// ----------------------------------------------------------------------------
module orbit_camera_pose_update (
   input  logic              clock,
   input  logic              reset,
   ocpu_req_if.sink          req,
   ocpu_rsp_if.source        rsp,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [30:0] min_ff, max_ff;
   ocpu_pkg::dp_cmd_type    cmd;
   ocpu_pkg::dp_status_type status;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= 31'(ocpu_pkg::FX_ONE);
         max_ff <= 31'(ocpu_pkg::FX_100);
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr)
            ocpu_pkg::REG_MIN_DIST: min_ff <= csr_pwdata[30:0];
            ocpu_pkg::REG_MAX_DIST: max_ff <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         ocpu_pkg::REG_MIN_DIST: csr_prdata = {1'b0, min_ff};
         ocpu_pkg::REG_MAX_DIST: csr_prdata = {1'b0, max_ff};
         default:                csr_prdata = '0;
      endcase
   end

   ocpu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   ocpu_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_op              (req.op),
      .req_yaw_step        (req.yaw_step),
      .req_pitch_step      (req.pitch_step),
      .req_zoom_delta      (req.zoom_delta),
      .req_pan_right       (req.pan_right),
      .req_pan_up          (req.pan_up),
      .req_new_target_x    (req.new_target_x),
      .req_new_target_y    (req.new_target_y),
      .req_new_target_z    (req.new_target_z),
      .min_dist            (min_ff),
      .max_dist            (max_ff),
      .cam_x               (rsp.cam_x),
      .cam_y               (rsp.cam_y),
      .cam_z               (rsp.cam_z),
      .look_x              (rsp.look_x),
      .look_y              (rsp.look_y),
      .look_z              (rsp.look_z),
      .range_now           (rsp.range_now)
   );

endmodule

// ===== rtl/ocpu_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocpu_datapath
// Camera state, shared CORDIC, shared multiplier and result register.
// ----------------------------------------------------------------------------
module ocpu_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  ocpu_pkg::dp_cmd_type     cmd,
   output ocpu_pkg::dp_status_type  status,
   input  logic [1:0]               req_op,
   input  logic signed [25:0]       req_yaw_step,
   input  logic signed [31:0]       req_pitch_step,
   input  logic signed [31:0]       req_zoom_delta,
   input  logic signed [31:0]       req_pan_right,
   input  logic signed [31:0]       req_pan_up,
   input  logic signed [31:0]       req_new_target_x,
   input  logic signed [31:0]       req_new_target_y,
   input  logic signed [31:0]       req_new_target_z,
   input  logic [30:0]              min_dist,
   input  logic [30:0]              max_dist,
   output logic signed [31:0]       cam_x,
   output logic signed [31:0]       cam_y,
   output logic signed [31:0]       cam_z,
   output logic signed [31:0]       look_x,
   output logic signed [31:0]       look_y,
   output logic signed [31:0]       look_z,
   output logic [30:0]              range_now
);

   // state
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic [30:0]        range_ff;
   logic [24:0]        head_ff;     // always within 0..360 degrees
   logic signed [23:0] tilt_ff;
   logic [1:0]         op_ff;
   logic signed [31:0] dx_ff, dy_ff;

   // cordic
   logic signed [33:0] cx_ff, cy_ff;
   logic signed [35:0] ca_ff;
   logic               neg_ff;
   logic [4:0]         step_ff;

   // trig results, Q2.30
   logic signed [31:0] sa_ff, ca_r_ff, se_ff, ce_ff;

   // multiplier and scratch
   logic signed [63:0] prod_ff;
   logic signed [31:0] t_ff, dys_ff;
   logic signed [47:0] accx_ff, accz_ff;

   // ---------------- cordic start -----------------
   logic signed [35:0] ang_src, a0, a1;
   logic               neg0;
   always_comb begin
      if (cmd.code == ocpu_pkg::CMD_CS_HEAD)
         ang_src = 36'(head_ff) <<< (ocpu_pkg::ANG_FRAC - ocpu_pkg::FRAC_BITS);
      else
         ang_src = 36'(tilt_ff) <<< (ocpu_pkg::ANG_FRAC - ocpu_pkg::FRAC_BITS);
      a0 = ang_src;
      if (a0 > ocpu_pkg::ANG_HALF)
         a0 = a0 - ocpu_pkg::ANG_FULL;
      if (a0 < -ocpu_pkg::ANG_HALF)
         a0 = a0 + ocpu_pkg::ANG_FULL;
      neg0 = 1'b0;
      a1   = a0;
      if (a0 > ocpu_pkg::ANG_QUART) begin
         a1   = a0 - ocpu_pkg::ANG_HALF;
         neg0 = 1'b1;
      end else if (a0 < -ocpu_pkg::ANG_QUART) begin
         a1   = a0 + ocpu_pkg::ANG_HALF;
         neg0 = 1'b1;
      end
   end

   logic signed [33:0] xs, ys;
   logic signed [35:0] atn;
   assign xs  = cx_ff >>> step_ff;
   assign ys  = cy_ff >>> step_ff;
   assign atn = ocpu_pkg::atan_lut(step_ff);
   assign status.cordic_last = (step_ff == 5'(ocpu_pkg::CORDIC_STEPS - 1));
   assign status.op = op_ff;

   logic signed [31:0] sin_v, cos_v;
   assign sin_v = neg_ff ? -cy_ff[31:0] : cy_ff[31:0];
   assign cos_v = neg_ff ? -cx_ff[31:0] : cx_ff[31:0];

   // ---------------- multiplier operand select -----------------
   logic signed [31:0] m_a, m_b;
   always_comb begin
      m_a = '0;
      m_b = '0;
      case (cmd.mul_sel)
         4'd0: begin m_a = dy_ff;  m_b = se_ff;   end  // dys
         4'd1: begin m_a = dx_ff;  m_b = ca_r_ff; end
         4'd2: begin m_a = dys_ff; m_b = sa_ff;   end
         4'd3: begin m_a = dy_ff;  m_b = ce_ff;   end
         4'd4: begin m_a = dx_ff;  m_b = sa_ff;   end
         4'd5: begin m_a = dys_ff; m_b = ca_r_ff; end
         4'd6: begin m_a = 32'(range_ff); m_b = ce_ff; end  // t
         4'd7: begin m_a = 32'(range_ff); m_b = se_ff; end
         4'd8: begin m_a = t_ff;   m_b = sa_ff;   end
         4'd9: begin m_a = t_ff;   m_b = ca_r_ff; end
         default: begin m_a = '0; m_b = '0; end
      endcase
   end
   // previous product, shifted
   logic signed [47:0] q;
   assign q = 48'(prod_ff >>> 30);

   // ---------------- orbit / zoom arithmetic -----------------
   logic signed [47:0] da, hsum, tsum, zsum;
   always_comb begin
      da = 48'(req_yaw_step);
      if (da > ocpu_pkg::FX_360)
         da = ocpu_pkg::FX_360;
      if (da < -ocpu_pkg::FX_360)
         da = -ocpu_pkg::FX_360;
      hsum = 48'(head_ff) + da;
      if (hsum > ocpu_pkg::FX_360)
         hsum = hsum - ocpu_pkg::FX_360;
      if (hsum < 0)
         hsum = hsum + ocpu_pkg::FX_360;
      tsum = 48'(tilt_ff) + 48'(req_pitch_step);
      if (tsum > ocpu_pkg::FX_89)
         tsum = ocpu_pkg::FX_89;
      if (tsum < -ocpu_pkg::FX_89)
         tsum = -ocpu_pkg::FX_89;
      zsum = 48'(range_ff) - 48'(req_zoom_delta);
      if (zsum < $signed(48'(min_dist)))
         zsum = 48'(min_dist);
      if (zsum > $signed(48'(max_dist)))
         zsum = 48'(max_dist);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff    <= '0;
         py_ff    <= '0;
         pz_ff    <= '0;
         range_ff <= 31'(ocpu_pkg::FX_10);
         head_ff  <= '0;
         tilt_ff  <= 24'(ocpu_pkg::FX_30);
         op_ff    <= ocpu_pkg::OP_ORBIT;
         step_ff  <= '0;
      end else begin
         case (cmd.code)
            ocpu_pkg::CMD_LOAD: begin
               op_ff <= req_op;
               dx_ff <= req_pan_right;
               dy_ff <= req_pan_up;
               case (req_op)
                  ocpu_pkg::OP_ORBIT: begin
                     head_ff <= 25'(hsum);
                     tilt_ff <= 24'(tsum);
                  end
                  ocpu_pkg::OP_ZOOM: range_ff <= 31'(zsum);
                  ocpu_pkg::OP_SET: begin
                     px_ff <= req_new_target_x;
                     py_ff <= req_new_target_y;
                     pz_ff <= req_new_target_z;
                  end
                  default: ;
               endcase
            end
            ocpu_pkg::CMD_CS_HEAD, ocpu_pkg::CMD_CS_TILT: begin
               cx_ff   <= ocpu_pkg::CORDIC_GAIN;
               cy_ff   <= '0;
               ca_ff   <= a1;
               neg_ff  <= neg0;
               step_ff <= '0;
            end
            ocpu_pkg::CMD_CS_STEP: begin
               if (ca_ff >= 0) begin
                  cx_ff <= cx_ff - ys;
                  cy_ff <= cy_ff + xs;
                  ca_ff <= ca_ff - atn;
               end else begin
                  cx_ff <= cx_ff + ys;
                  cy_ff <= cy_ff - xs;
                  ca_ff <= ca_ff + atn;
               end
               step_ff <= step_ff + 5'd1;
            end
            ocpu_pkg::CMD_CS_HEAD_DONE: begin
               sa_ff   <= sin_v;
               ca_r_ff <= cos_v;
            end
            ocpu_pkg::CMD_CS_TILT_DONE: begin
               se_ff <= sin_v;
               ce_ff <= cos_v;
            end
            ocpu_pkg::CMD_MUL: begin
               prod_ff <= 64'(m_a) * 64'(m_b);
               // consume the product of the previous slot
               case (cmd.mul_sel)
                  4'd1: dys_ff  <= q[31:0];
                  4'd2: accx_ff <= 48'(px_ff) + q;
                  4'd3: accx_ff <= accx_ff - q;
                  4'd4: py_ff   <= ocpu_pkg::sat32(48'(py_ff) + q);
                  4'd5: accz_ff <= 48'(pz_ff) - q;
                  4'd7: t_ff    <= q[31:0];
                  4'd8: cam_y   <= ocpu_pkg::sat32(48'(py_ff) + q);
                  4'd9: cam_x   <= ocpu_pkg::sat32(48'(px_ff) + q);
                  default: ;
               endcase
            end
            ocpu_pkg::CMD_PAN_DONE: begin
               px_ff <= ocpu_pkg::sat32(accx_ff);
               pz_ff <= ocpu_pkg::sat32(accz_ff - q);
            end
            ocpu_pkg::CMD_OUT: begin
               cam_z     <= ocpu_pkg::sat32(48'(pz_ff) + q);
               look_x    <= px_ff;
               look_y    <= py_ff;
               look_z    <= pz_ff;
               range_now <= range_ff;
            end
            default: ;
         endcase
      end
   end

endmodule

// ===== rtl/ocpu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocpu_ctrl
// Sequencer: load, sine/cosine passes, multiply slots, result handshake.
// ----------------------------------------------------------------------------
module ocpu_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ocpu_pkg::dp_cmd_type     cmd,
   input  ocpu_pkg::dp_status_type  status
);

   typedef enum logic [3:0] {
      S_IDLE, S_HSTART, S_HRUN, S_HDONE, S_TSTART, S_TRUN, S_TDONE,
      S_PAN, S_PANDONE, S_POS, S_OUT, S_HOLD
   } state_type;

   state_type  state_ff;
   logic       post_ff;     // second sin/cos pass after pan
   logic [3:0] slot_ff;
   logic       rsp_valid_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.code    = ocpu_pkg::CMD_NONE;
      cmd.mul_sel = slot_ff;
      unique case (state_ff)
         S_IDLE:    if (req_valid) cmd.code = ocpu_pkg::CMD_LOAD;
         S_HSTART:  cmd.code = ocpu_pkg::CMD_CS_HEAD;
         S_HRUN:    cmd.code = ocpu_pkg::CMD_CS_STEP;
         S_HDONE:   cmd.code = ocpu_pkg::CMD_CS_HEAD_DONE;
         S_TSTART:  cmd.code = ocpu_pkg::CMD_CS_TILT;
         S_TRUN:    cmd.code = ocpu_pkg::CMD_CS_STEP;
         S_TDONE:   cmd.code = ocpu_pkg::CMD_CS_TILT_DONE;
         S_PAN:     cmd.code = ocpu_pkg::CMD_MUL;
         S_PANDONE: cmd.code = ocpu_pkg::CMD_PAN_DONE;
         S_POS:     cmd.code = ocpu_pkg::CMD_MUL;
         S_OUT:     cmd.code = ocpu_pkg::CMD_OUT;
         S_HOLD:    cmd.code = ocpu_pkg::CMD_NONE;
         default:   cmd.code = ocpu_pkg::CMD_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         post_ff      <= 1'b0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               state_ff <= S_HSTART;
               post_ff  <= 1'b0;
            end
            S_HSTART: state_ff <= S_HRUN;
            S_HRUN:   if (status.cordic_last) state_ff <= S_HDONE;
            S_HDONE:  state_ff <= S_TSTART;
            S_TSTART: state_ff <= S_TRUN;
            S_TRUN:   if (status.cordic_last) state_ff <= S_TDONE;
            S_TDONE: begin
               if (status.op == ocpu_pkg::OP_PAN && !post_ff) begin
                  state_ff <= S_PAN;
                  slot_ff  <= 4'd0;
               end else begin
                  state_ff <= S_POS;
                  slot_ff  <= 4'd6;
               end
            end
            // slots 0..5 multiply; the last product is taken in S_PANDONE
            S_PAN: begin
               if (slot_ff == 4'd5)
                  state_ff <= S_PANDONE;
               slot_ff <= slot_ff + 4'd1;
            end
            S_PANDONE: begin
               state_ff <= S_HSTART;
               post_ff  <= 1'b1;
            end
            // slots 6..9 multiply; the last product is taken in S_OUT
            S_POS: begin
               if (slot_ff == 4'd9)
                  state_ff <= S_OUT;
               slot_ff <= slot_ff + 4'd1;
            end
            S_OUT: begin
               state_ff     <= S_HOLD;
               rsp_valid_ff <= 1'b1;
            end
            S_HOLD: if (rsp_ready) begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/ocpu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocpu_checker
// Port-level checks for the orbit camera pose unit.
// ----------------------------------------------------------------------------
module ocpu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [30:0] rsp_range_now,
   input logic        csr_pready
);

   // one item in flight: no new transfer while a result waits
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("item accepted while result pending");

   // result never appears right after acceptance
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("result too early");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_range_now)))
      else $error("stalled result changed");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

endmodule

bind orbit_camera_pose_update ocpu_checker u_ocpu_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_range_now (rsp.range_now),
   .csr_pready    (csr_pready)
);

// ===== test/tb_orbit_camera_pose_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_orbit_camera_pose_update
// Self-checking bench for the orbit camera pose unit.
// ----------------------------------------------------------------------------
// Drives orbit, zoom, pan and set-target items over req with random gaps,
// stalls rsp at random and compares every result field against a
// cycle-free model of the camera state (CORDIC sine/cosine included).
// The distance limits are rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_orbit_camera_pose_update;

   typedef struct {
      logic [1:0]         op;
      logic signed [25:0] d_az;
      logic signed [31:0] d_el;
      logic signed [31:0] zoom;
      logic signed [31:0] pan_r;
      logic signed [31:0] pan_u;
      logic signed [31:0] tx;
      logic signed [31:0] ty;
      logic signed [31:0] tz;
   } pose_cmd_type;

   typedef struct {
      logic signed [31:0] cam_x, cam_y, cam_z;
      logic signed [31:0] look_x, look_y, look_z;
      logic [30:0]        range_now;
   } pose_type;

   localparam longint ATAN_DEG22 [24] = '{
      188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
      3754631, 1877430, 938729, 469366, 234683, 117342,
      58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29};
   localparam longint Q1  = 64'sd1 << 16;
   localparam longint DEG360 = 360 * Q1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ocpu_req_if req_if ();
   ocpu_rsp_if rsp_if ();

   orbit_camera_pose_update dut (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // camera state as predicted
   longint   tgt_x, tgt_y, tgt_z, orbit_len, azim, elev;
   longint   dist_min, dist_max;
   pose_type pose_q[$];
   int       err_cnt = 0;
   bit       send_gaps = 1'b1;
   bit       recv_stalls = 1'b1;
   int       hold_cycles = 0;

   function automatic longint clip_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint scale_q30(longint v, longint q);
      return (v * q) >>> 30;
   endfunction

   function automatic void deg_sincos(input longint ang, output longint s,
                                      output longint c);
      longint a, x, y, nx;
      bit     flip;
      a = ang * 64;   // Q16 -> Q22 degrees
      x = 652032874;
      y = 0;
      flip = 1'b0;
      if (a > (64'sd180 << 22)) a -= 64'sd360 << 22;
      if (a < -(64'sd180 << 22)) a += 64'sd360 << 22;
      if (a > (64'sd90 << 22)) begin
         a -= 64'sd180 << 22;
         flip = 1'b1;
      end else if (a < -(64'sd90 << 22)) begin
         a += 64'sd180 << 22;
         flip = 1'b1;
      end
      for (int i = 0; i < 24; i++) begin
         if (a >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            a -= ATAN_DEG22[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            a += ATAN_DEG22[i];
         end
         x = nx;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic pose_type apply_pose_cmd(pose_cmd_type c);
      longint   sa, ca, se, ce, t, dx, dy, dys, da;
      pose_type p;
      case (c.op)
         ocpu_pkg::OP_ORBIT: begin
            da = longint'(c.d_az);
            if (da > DEG360) da = DEG360;
            if (da < -DEG360) da = -DEG360;
            t = elev + longint'(c.d_el);
            elev = t > 89 * Q1 ? 89 * Q1 : (t < -89 * Q1 ? -89 * Q1 : t);
            azim += da;
            if (azim > DEG360) azim -= DEG360;
            if (azim < 0) azim += DEG360;
         end
         ocpu_pkg::OP_ZOOM: begin
            t = orbit_len - longint'(c.zoom);
            if (t < dist_min) t = dist_min;
            if (t > dist_max) t = dist_max;
            orbit_len = t;
         end
         ocpu_pkg::OP_PAN: begin
            dx = longint'(c.pan_r);
            dy = longint'(c.pan_u);
            deg_sincos(azim, sa, ca);
            deg_sincos(elev, se, ce);
            dys = scale_q30(dy, se);
            tgt_x = clip_word(tgt_x + scale_q30(dx, ca) - scale_q30(dys, sa));
            tgt_y = clip_word(tgt_y + scale_q30(dy, ce));
            tgt_z = clip_word(tgt_z - scale_q30(dx, sa) - scale_q30(dys, ca));
         end
         default: begin
            tgt_x = longint'(c.tx);
            tgt_y = longint'(c.ty);
            tgt_z = longint'(c.tz);
         end
      endcase
      deg_sincos(azim, sa, ca);
      deg_sincos(elev, se, ce);
      t = scale_q30(orbit_len, ce);
      p.cam_x = clip_word(tgt_x + scale_q30(t, sa));
      p.cam_y = clip_word(tgt_y + scale_q30(orbit_len, se));
      p.cam_z = clip_word(tgt_z + scale_q30(t, ca));
      p.look_x = tgt_x;
      p.look_y = tgt_y;
      p.look_z = tgt_z;
      p.range_now = orbit_len[30:0];
      return p;
   endfunction

   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // one item: offer at falling edge, hold until transfer
   task automatic send_pose_cmd(pose_cmd_type c);
      int gap;
      @(negedge clock);
      req_if.op = c.op;
      req_if.yaw_step = c.d_az;
      req_if.pitch_step = c.d_el;
      req_if.zoom_delta = c.zoom;
      req_if.pan_right = c.pan_r;
      req_if.pan_up = c.pan_u;
      req_if.new_target_x = c.tx;
      req_if.new_target_y = c.ty;
      req_if.new_target_z = c.tz;
      req_if.valid = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      pose_q.push_back(apply_pose_cmd(c));
      gap = send_gaps ? pick_idle() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_if.valid = 1'b0;
      wait (pose_q.size() == 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      logic [31:0] rd;
      @(negedge clock);
      csr_psel = 1'b1; csr_pwrite = 1'b1; csr_paddr = addr; csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ocpu_pkg::REG_MIN_DIST) dist_min = longint'(data[30:0]);
      if (addr == ocpu_pkg::REG_MAX_DIST) dist_max = longint'(data[30:0]);
      @(negedge clock);
      csr_penable = 1'b0; csr_pwrite = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0;
      if (rd[30:0] !== data[30:0]) begin
         $error("csr readback %0d: expected %h actual %h", addr, data[30:0], rd);
         err_cnt++;
      end
   endtask

   task automatic set_distance_limits(logic [31:0] lo, logic [31:0] hi);
      drain_results();
      csr_write(ocpu_pkg::REG_MIN_DIST, lo);
      csr_write(ocpu_pkg::REG_MAX_DIST, hi);
   endtask

   function automatic pose_cmd_type make_cmd(logic [1:0] op);
      pose_cmd_type c;
      c.op = op;
      c.d_az = 26'($urandom()); c.d_el = $urandom(); c.zoom = $urandom();
      c.pan_r = $urandom(); c.pan_u = $urandom();
      c.tx = $urandom(); c.ty = $urandom(); c.tz = $urandom();
      return c;
   endfunction

   function automatic logic signed [31:0] small_val(int span);
      return $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic pose_cmd_type make_random_cmd();
      pose_cmd_type c;
      c = make_cmd(2'($urandom_range(0, 3)));
      // mostly moderate values so state stays off the rails
      if ($urandom_range(0, 4) != 0) begin
         c.d_az = 26'(small_val(23592960));
         c.d_el = small_val(3 * 1966080);
         c.zoom = small_val(20 * 65536);
         c.pan_r = small_val(50 * 65536);
         c.pan_u = small_val(50 * 65536);
         c.tx = small_val(1000 * 65536);
         c.ty = small_val(1000 * 65536);
         c.tz = small_val(1000 * 65536);
      end
      return c;
   endfunction

   task automatic test_reset_pose();
      pose_cmd_type c;
      c = make_cmd(ocpu_pkg::OP_ZOOM);
      c.zoom = 0;
      send_pose_cmd(c);
      c = make_cmd(ocpu_pkg::OP_ORBIT);
      c.d_az = 0; c.d_el = 0;
      send_pose_cmd(c);
      drain_results();
   endtask

   task automatic test_field_extremes();
      pose_cmd_type c;
      logic signed [31:0] ends [2] = '{32'sh7FFF_FFFF, 32'sh8000_0000};
      foreach (ends[i]) begin
         c = make_cmd(ocpu_pkg::OP_ORBIT);     // azimuth delta beyond 360 saturates
         c.d_az = i ? 26'sh200_0000 : 26'sh1FF_FFFF;
         c.d_el = ends[i];
         send_pose_cmd(c);
         c = make_cmd(ocpu_pkg::OP_ZOOM);
         c.zoom = ends[i];
         send_pose_cmd(c);
         c = make_cmd(ocpu_pkg::OP_PAN);
         c.pan_r = ends[i]; c.pan_u = ends[1 - i];
         send_pose_cmd(c);
         c = make_cmd(ocpu_pkg::OP_SET);
         c.tx = ends[i]; c.ty = ends[i]; c.tz = ends[1 - i];
         send_pose_cmd(c);
      end
      // azimuth wrap above 360 and below 0
      c = make_cmd(ocpu_pkg::OP_ORBIT);
      c.d_el = 0; c.d_az = 26'(350 * 65536);
      send_pose_cmd(c);
      c.d_az = 26'(20 * 65536);
      send_pose_cmd(c);
      c.d_az = 26'(-30 * 65536);
      send_pose_cmd(c);
      c.d_az = 26'(-360 * 65536);
      send_pose_cmd(c);
      c.d_az = 26'(360 * 65536);
      send_pose_cmd(c);
      // position overflow: target at max, distance at max
      c = make_cmd(ocpu_pkg::OP_SET);
      c.tx = 32'sh7FFF_FFF0; c.ty = 32'sh7FFF_FFF0; c.tz = 32'sh8000_0010;
      send_pose_cmd(c);
      c = make_cmd(ocpu_pkg::OP_ZOOM);
      c.zoom = 32'sh8000_0000;
      send_pose_cmd(c);
      c = make_cmd(ocpu_pkg::OP_ORBIT);
      c.d_az = 26'(180 * 65536); c.d_el = -40 * 65536;
      send_pose_cmd(c);
      drain_results();
   endtask

   task automatic test_distance_limits();
      pose_cmd_type c;
      logic [31:0] lim [5][2] = '{
         '{32'h0000_0000, 32'h7FFF_FFFF},
         '{32'hFFFF_FFFF, 32'h7FFF_FFFF},
         '{32'h0032_0000, 32'h0005_0000},   // min above max
         '{32'h0010_0000, 32'h0010_0000},
         '{32'h8000_0000, 32'h0000_0000}};
      foreach (lim[k]) begin
         set_distance_limits(lim[k][0], lim[k][1]);
         repeat (4) begin
            c = make_cmd(ocpu_pkg::OP_ZOOM);
            if ($urandom_range(0, 1)) c.zoom = small_val(30 * 65536);
            send_pose_cmd(c);
         end
      end
      set_distance_limits(32'h0001_0000, 32'h0064_0000);
   endtask

   task automatic test_random_ops(int count);
      for (int n = 0; n < count; n++) begin
         if (n % 400 == 399) begin
            case ((n / 400) % 4)
               0: set_distance_limits($urandom(), $urandom());
               1: set_distance_limits(0, 32'h7FFF_FFFF);
               2: set_distance_limits($urandom_range(0, 5 << 16),
                                      $urandom_range(20 << 16, 200 << 16));
               default: set_distance_limits(32'h0001_0000, 32'h0064_0000);
            endcase
            // a stretch without idling on either side
            send_gaps = ((n / 400) % 2) == 0;
            recv_stalls = send_gaps;
         end
         send_pose_cmd(make_random_cmd());
      end
      send_gaps = 1'b1;
      recv_stalls = 1'b1;
      drain_results();
   endtask

   task automatic test_backpressure();
      send_gaps = 1'b0;
      hold_cycles = 400;
      repeat (6) send_pose_cmd(make_random_cmd());
      drain_results();
      repeat (4) send_pose_cmd(make_random_cmd());
      send_gaps = 1'b1;
      drain_results();
   endtask

   // result sink: ready pattern, long hold-offs counted here
   initial begin
      int stall;
      stall = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_if.ready = 1'b0;
            hold_cycles--;
         end else if (stall > 0) begin
            rsp_if.ready = 1'b0;
            stall--;
         end else begin
            rsp_if.ready = 1'b1;
            if (recv_stalls) stall = pick_idle();
         end
      end
   end

   // compare each transfer on rsp with the oldest prediction
   initial begin
      pose_type e;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pose_q.size() == 0) begin
               $error("result transfer with no item outstanding");
               err_cnt++;
            end else begin
               e = pose_q.pop_front();
               if (rsp_if.cam_x !== e.cam_x) begin
                  $error("cam_x: expected %0d actual %0d", e.cam_x, rsp_if.cam_x);
                  err_cnt++;
               end
               if (rsp_if.cam_y !== e.cam_y) begin
                  $error("cam_y: expected %0d actual %0d", e.cam_y, rsp_if.cam_y);
                  err_cnt++;
               end
               if (rsp_if.cam_z !== e.cam_z) begin
                  $error("cam_z: expected %0d actual %0d", e.cam_z, rsp_if.cam_z);
                  err_cnt++;
               end
               if (rsp_if.look_x !== e.look_x) begin
                  $error("look_x: expected %0d actual %0d", e.look_x, rsp_if.look_x);
                  err_cnt++;
               end
               if (rsp_if.look_y !== e.look_y) begin
                  $error("look_y: expected %0d actual %0d", e.look_y, rsp_if.look_y);
                  err_cnt++;
               end
               if (rsp_if.look_z !== e.look_z) begin
                  $error("look_z: expected %0d actual %0d", e.look_z, rsp_if.look_z);
                  err_cnt++;
               end
               if (rsp_if.range_now !== e.range_now) begin
                  $error("range_now: expected %0d actual %0d", e.range_now,
                         rsp_if.range_now);
                  err_cnt++;
               end
            end
         end
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.op = ocpu_pkg::OP_ORBIT;
      req_if.yaw_step = '0;
      req_if.pitch_step = '0;
      req_if.zoom_delta = '0;
      req_if.pan_right = '0;
      req_if.pan_up = '0;
      req_if.new_target_x = '0;
      req_if.new_target_y = '0;
      req_if.new_target_z = '0;
      tgt_x = 0; tgt_y = 0; tgt_z = 0;
      orbit_len = 10 * Q1; azim = 0; elev = 30 * Q1;
      dist_min = Q1; dist_max = 100 * Q1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_pose();
      test_field_extremes();
      test_distance_limits();
      test_backpressure();
      test_random_ops(1900);

      @(negedge clock);
      req_if.valid = 1'b0;
      wait (pose_q.size() == 0);
      repeat (200) @(posedge clock);
      if (err_cnt == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #30ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== orbit_camera_pose_update.f =====
rtl/ocpu_pkg.sv
rtl/ocpu_stream_if.sv
rtl/ocpu_datapath.sv
rtl/ocpu_ctrl.sv
rtl/orbit_camera_pose_update.sv
rtl/ocpu_checker.sv
test/tb_orbit_camera_pose_update.sv
